### rtl/sass_pkg.sv
// Shared constants for the slew-adaptive stereo smoother.
// No dependencies.
package sass_pkg;
    localparam int unsigned ONE_Q16 = 65536;
    localparam logic CFG_SENSE_GAIN = 1'b0;
    localparam logic CFG_WET_MIX = 1'b1;
endpackage

### rtl/sass_lane.sv
// One channel lane of the slew-adaptive smoother: a sequenced datapath.
// Depends on sass_pkg.
module sass_lane import sass_pkg::*; #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    input  logic [31:0]                   i_gain,
    input  logic [16:0]                   i_wet,
    output logic                          o_done,
    output logic signed [SAMPLE_BITS-1:0] o_y
);
    localparam int SB = SAMPLE_BITS;
    localparam int CW = SB + 2;
    localparam int UP = (SB < 24) ? 24 - SB : 0;
    localparam int DN = (SB > 24) ? SB - 24 : 0;
    localparam int PW = 2 * (CW + UP);
    localparam int QW = ((PW + 4 + 15) / 16) * 16;
    localparam int ND = QW / 16;
    localparam longint unsigned M3 = ((64'd1 << (SB + 2)) + 64'd2) / 64'd3;
    localparam logic [20:0] DIV13_M = 21'd1290556;
    localparam logic signed [SB+18:0] Y_HI = (SB+19)'({1'b0, {(SB-1){1'b1}}});
    localparam logic signed [SB+18:0] Y_LO = -Y_HI - (SB+19)'(1);

    localparam logic [3:0] S_IDLE = 4'd0, S_MEAN = 4'd1, S_PROD = 4'd2, S_Q = 4'd3,
        S_GLO = 4'd4, S_DIV = 4'd5, S_SENSE = 4'd6, S_BL1 = 4'd7, S_BL2 = 4'd8,
        S_AC1 = 4'd9, S_AC2 = 4'd10, S_MX1 = 4'd11, S_MX2 = 4'd12, S_OUT = 4'd13;

    logic [3:0] r_st;
    logic signed [SB-1:0] r_s2, r_s3, r_lb, r_x, r_y;
    logic [16:0] r_h1, r_h2, r_s;
    logic signed [SB+1:0] r_mean;
    logic [PW-1:0] r_p;
    logic [QW-1:0] r_q;
    logic [3:0] r_rem;
    logic [2:0] r_dig;
    logic [63:0] r_t;
    logic signed [SB+18:0] r_a;
    logic signed [SB-1:0] r_bl, r_acc;
    logic r_done;

    logic signed [SB+1:0] sum3, d0, e0;
    logic [SB+1:0] mu, mq;
    logic [2*SB+3:0] mprod;
    logic [19:0] dv;
    logic [39:0] dpr;
    logic [15:0] dq;
    logic [3:0] dr4;
    logic signed [CW+UP-1:0] dc, ec;
    logic [CW+UP-1:0] dm, em;
    logic [16:0] raw, smax, hh, ww;
    logic [63:0] graw;
    logic signed [SB+18:0] ysum;

    function automatic logic signed [CW+UP-1:0] to_curv(input logic signed [SB+1:0] v);
        logic signed [CW+UP-1:0] t;
        t = (CW+UP)'(v);
        if (DN > 0) to_curv = t >>> DN;
        else        to_curv = t <<< UP;
    endfunction

    assign sum3 = (SB+2)'(r_x) + (SB+2)'(r_s2) + (SB+2)'(r_s3);
    assign mu = sum3[SB+1] ? (SB+2)'(-sum3) : (SB+2)'(sum3);
    assign mprod = (2*SB+4)'(mu) * (2*SB+4)'(M3);
    assign mq = mprod[2*SB+3:SB+2];
    assign dv = {r_rem, r_q[QW-1 -: 16]};
    assign dpr = 40'(dv) * 40'(DIV13_M);
    assign dq = dpr[39:24];
    assign dr4 = 4'(dv - 20'(dq) * 20'd13);
    assign d0 = (SB+2)'(r_x) - (SB+2)'(r_s2);
    assign e0 = d0 - ((SB+2)'(r_s2) - (SB+2)'(r_s3));
    assign dc = to_curv(d0);
    assign ec = to_curv(e0);
    assign dm = dc[CW+UP-1] ? (CW+UP)'(-dc) : (CW+UP)'(dc);
    assign em = ec[CW+UP-1] ? (CW+UP)'(-ec) : (CW+UP)'(ec);
    assign graw = r_t >> 18;
    assign raw = (graw > 64'(ONE_Q16)) ? 17'(ONE_Q16) : graw[16:0];
    assign smax = (r_h1 > raw ? r_h1 : raw) > r_h2 ? (r_h1 > raw ? r_h1 : raw) : r_h2;
    assign hh = {1'b0, r_s[16:1]};
    assign ww = (i_wet > 17'(ONE_Q16)) ? 17'(ONE_Q16) : i_wet;
    assign ysum = r_a >>> 16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
            r_st <= S_IDLE;
            r_s2 <= '0; r_s3 <= '0; r_lb <= '0; r_h1 <= '0; r_h2 <= '0;
        end else begin
            r_done <= (r_st == S_OUT);
            unique case (r_st)
                S_IDLE: if (i_start) begin
                    r_x <= i_x;
                    r_st <= S_MEAN;
                end
                S_MEAN: begin
                    r_mean <= sum3[SB+1] ? -$signed(mq) : $signed(mq);
                    r_p <= PW'(dm) * PW'(em);
                    r_st <= S_PROD;
                end
                S_PROD: begin
                    r_q <= QW'(r_p) * QW'(10);
                    r_rem <= '0;
                    r_dig <= 3'(ND - 1);
                    r_st <= S_DIV;
                end
                S_DIV: begin
                    r_q <= {r_q[QW-17:0], dq};
                    r_rem <= dr4;
                    if (r_dig == '0) r_st <= S_Q;
                    else r_dig <= r_dig - 3'd1;
                end
                S_Q: begin
                    r_t <= ((64'(i_gain) * 64'(r_q[31:0])) >> 32);
                    r_st <= S_GLO;
                end
                S_GLO: begin
                    r_t <= r_t + 64'(i_gain) * 64'(r_q[PW+3:32]);
                    r_st <= S_SENSE;
                end
                S_SENSE: begin
                    r_s <= smax;
                    r_h2 <= r_h1;
                    r_h1 <= raw;
                    r_s3 <= r_s2;
                    r_s2 <= r_x;
                    r_st <= S_BL1;
                end
                S_BL1: begin
                    r_a <= (SB+19)'(r_x) * $signed({1'b0, 17'(ONE_Q16) - r_s});
                    r_st <= S_BL2;
                end
                S_BL2: begin
                    r_a <= r_a + (SB+19)'(r_mean) * $signed({1'b0, r_s});
                    r_st <= S_AC1;
                end
                S_AC1: begin
                    r_bl <= SB'(ysum);
                    r_a <= (SB+19)'(r_lb) * $signed({1'b0, hh});
                    r_st <= S_AC2;
                end
                S_AC2: begin
                    r_a <= r_a + (SB+19)'(r_bl) * $signed({1'b0, 17'(ONE_Q16) - hh});
                    r_lb <= r_bl;
                    r_st <= S_MX1;
                end
                S_MX1: begin
                    r_acc <= SB'(ysum);
                    r_a <= (SB+19)'(r_x) * $signed({1'b0, 17'(ONE_Q16) - ww});
                    r_st <= S_MX2;
                end
                S_MX2: begin
                    r_a <= r_a + (SB+19)'(r_acc) * $signed({1'b0, ww});
                    r_st <= S_OUT;
                end
                S_OUT: begin
                    if (ysum > Y_HI)
                        r_y <= {1'b0, {(SB-1){1'b1}}};
                    else if (ysum < Y_LO)
                        r_y <= {1'b1, {(SB-1){1'b0}}};
                    else
                        r_y <= SB'(ysum);
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_y = r_y;
endmodule

### rtl/slew_adaptive_stereo_smoother.sv
// Slew-adaptive stereo smoother: one lane per channel, merged output register.
// Each accepted beat runs through the lane sequencer states and then the merged output register; one beat in flight.
// A new pair is accepted only after the lane sequencer has finished the last pair and its output has been taken.
// Synchronous active-low reset clears history, config to defaults, valids.
// Depends on sass_pkg and sass_lane.
module slew_adaptive_stereo_smoother import sass_pkg::*; #(
    parameter int SAMPLE_BITS = 24,
    parameter int CHANNELS = 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_left_in,
    input  logic signed [SAMPLE_BITS-1:0] i_right_in,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [SAMPLE_BITS-1:0] o_left_out,
    output logic signed [SAMPLE_BITS-1:0] o_right_out,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);
    logic [31:0] r_gain;
    logic [16:0] r_wet;
    logic r_busy, r_ov;
    logic signed [SAMPLE_BITS-1:0] r_l, r_r;
    logic start, dl, dr;
    logic signed [SAMPLE_BITS-1:0] yl, yr;

    assign o_stall = r_busy || r_ov;
    assign start = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    sass_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_l (.i_clk, .i_rst_n, .i_start(start),
        .i_x(i_left_in), .i_gain(r_gain), .i_wet(r_wet), .o_done(dl), .o_y(yl));
    sass_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_r (.i_clk, .i_rst_n, .i_start(start),
        .i_x(i_right_in), .i_gain(r_gain), .i_wet(r_wet), .o_done(dr), .o_y(yr));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= 32'd1073741824;
            r_wet <= 17'(ONE_Q16);
            r_busy <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_SENSE_GAIN) r_gain <= i_cfg_data;
                else r_wet <= i_cfg_data[16:0];
            end
            if (start) r_busy <= 1'b1;
            if (dl && dr) begin
                r_busy <= 1'b0;
                r_ov <= 1'b1;
                r_l <= yl;
                r_r <= (CHANNELS > 1) ? yr : '0;
            end else if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_valid = r_ov;
    assign o_left_out = r_l;
    assign o_right_out = r_r;
endmodule
